FILE: src/bps_pkg.sv
// Package with types and constants for the binary operation peephole simplifier.
package bps_pkg;

   localparam int unsigned DefaultWidth = 32;
   localparam int unsigned ValueBits = 32;
   localparam int unsigned RefBits = 16;

   // Operation codes of an incoming word.
   typedef enum logic [2:0] {
      MODE_ADD  = 3'd0,
      MODE_SUB  = 3'd1,
      MODE_MUL  = 3'd2,
      MODE_UDIV = 3'd3,
      MODE_SDIV = 3'd4
   } mode_type;

   // Rewrite actions of a result word.
   typedef enum logic [2:0] {
      ACT_KEEP  = 3'd0,
      ACT_FOLD  = 3'd1,
      ACT_OPND  = 3'd2,
      ACT_CONST = 3'd3,
      ACT_SHL   = 3'd4,
      ACT_LSHR  = 3'd5,
      ACT_ASHR  = 3'd6
   } action_type;

   // Input word.
   typedef struct packed {
      logic [2:0]           mode;
      logic [ValueBits-1:0] left_value;
      logic                 left_is_const;
      logic [RefBits-1:0]   left_ref;
      logic [ValueBits-1:0] right_value;
      logic                 right_is_const;
      logic [RefBits-1:0]   right_ref;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [2:0]           action;
      logic [ValueBits-1:0] result_value;
      logic [RefBits-1:0]   operand_ref;
      logic                 div_by_zero;
   } rsp_type;

   // Classified word handed from the front part to the back part.
   typedef enum logic [1:0] {
      CLS_DONE = 2'd0,
      CLS_ARITH = 2'd1,
      CLS_UDIV = 2'd2,
      CLS_SDIV = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type              cls;
      logic [2:0]           mode;
      logic                 a_neg;
      logic                 b_neg;
      logic [ValueBits-1:0] a;
      logic [ValueBits-1:0] b;
      rsp_type              rsp;
   } job_type;

endpackage

FILE: src/binop_peephole_simplifier_unit.sv
// Throughput: one word per cycle; the divider has one pipeline stage per quotient bit.
// busy stays low after reset; the receiver cannot stall, so no queue fills.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
module binop_peephole_simplifier_unit import bps_pkg::*; #(
   parameter int unsigned WIDTH = DefaultWidth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   logic    f_valid;
   job_type f_job;

   // The back part never stalls, so the front can always take a word.
   assign busy = 1'b0;

   // Front part.
   bps_front #(.WIDTH(WIDTH)) u_front (
      .clock(clock), .reset(reset), .in_valid(start && !busy), .in_word(req_word),
      .out_valid(f_valid), .out_job(f_job)
   );

   // Back part.
   bps_back #(.WIDTH(WIDTH)) u_back (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_job(f_job),
      .out_valid(rsp_valid), .out_word(rsp_word)
   );

endmodule

FILE: src/bps_front.sv
// Front part: checks identities and powers of two and prepares the folding operands.
module bps_front import bps_pkg::*; #(
   parameter int unsigned WIDTH = DefaultWidth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_word,
   output logic    out_valid,
   output job_type out_job
);

   localparam int unsigned ShBits = $clog2(WIDTH);

   logic [WIDTH-1:0] lv, rv, mag_l, mag_r;
   logic             lc, rc, both, l_neg, r_neg, swap;
   logic [WIDTH-1:0] sv_v, so_v;
   logic             so_c;
   logic [RefBits-1:0] s_lr, s_rr;
   logic [ShBits-1:0] tz;
   job_type          job_in, job_ff;
   logic             valid_ff;

   // Narrow the constants to WIDTH bits, then find the trailing zero count.
   always_comb begin
      lv = WIDTH'(in_word.left_value);
      rv = WIDTH'(in_word.right_value);
      lc = in_word.left_is_const;
      rc = in_word.right_is_const;
      both = lc && rc && (in_word.mode <= 3'(MODE_SDIV));
      l_neg = lv[WIDTH-1];
      r_neg = rv[WIDTH-1];
      mag_l = l_neg ? (~lv + 1'b1) : lv;
      mag_r = r_neg ? (~rv + 1'b1) : rv;
      swap = lc && ((in_word.mode == 3'(MODE_ADD)) || (in_word.mode == 3'(MODE_MUL)));
      so_v = swap ? lv : rv;
      so_c = swap ? lc : rc;
      sv_v = swap ? rv : lv;
      s_lr = swap ? in_word.right_ref : in_word.left_ref;
      s_rr = swap ? in_word.left_ref : in_word.right_ref;
      tz = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (so_v[i]) tz = ShBits'(i);
      end
   end

   // Classify the word and settle every case that needs no arithmetic.
   always_comb begin
      job_in = '0;
      job_in.mode = in_word.mode;
      job_in.a = ValueBits'(lv);
      job_in.b = ValueBits'(rv);
      job_in.rsp.action = ACT_KEEP;
      job_in.cls = CLS_DONE;
      if (both) begin
         unique case (in_word.mode)
            3'(MODE_UDIV): begin
               if (rv == '0) job_in.rsp.div_by_zero = 1'b1;
               else job_in.cls = CLS_UDIV;
            end
            3'(MODE_SDIV): begin
               if (rv == '0) job_in.rsp.div_by_zero = 1'b1;
               else begin
                  job_in.cls = CLS_SDIV;
                  job_in.a = ValueBits'(mag_l);
                  job_in.b = ValueBits'(mag_r);
                  job_in.a_neg = l_neg;
                  job_in.b_neg = r_neg;
               end
            end
            default: job_in.cls = CLS_ARITH;
         endcase
      end else if (in_word.mode <= 3'(MODE_SDIV)) begin
         priority if (in_word.mode == 3'(MODE_ADD) && so_c && so_v == '0) begin
            job_in.rsp.action = ACT_OPND;
            job_in.rsp.operand_ref = s_lr;
         end else if (in_word.mode == 3'(MODE_SUB) && so_c && so_v == '0) begin
            job_in.rsp.action = ACT_OPND;
            job_in.rsp.operand_ref = s_lr;
         end else if (in_word.mode == 3'(MODE_SUB) && s_lr == s_rr) begin
            job_in.rsp.action = ACT_CONST;
         end else if (in_word.mode == 3'(MODE_MUL) && so_c && so_v == '0) begin
            job_in.rsp.action = ACT_CONST;
         end else if (in_word.mode == 3'(MODE_MUL) && so_c && so_v == WIDTH'(1)) begin
            job_in.rsp.action = ACT_OPND;
            job_in.rsp.operand_ref = s_lr;
         end else if (in_word.mode >= 3'(MODE_UDIV) && s_lr == s_rr) begin
            job_in.rsp.action = ACT_CONST;
            job_in.rsp.result_value = ValueBits'(1);
         end else if (in_word.mode >= 3'(MODE_UDIV) && so_c && so_v == WIDTH'(1)) begin
            job_in.rsp.action = ACT_OPND;
            job_in.rsp.operand_ref = s_lr;
         end else if (in_word.mode >= 3'(MODE_UDIV) && lc && sv_v == '0) begin
            job_in.rsp.action = ACT_CONST;
         end else if (in_word.mode >= 3'(MODE_MUL) && so_c && so_v != '0
                      && (so_v & (so_v - 1'b1)) == '0) begin
            job_in.rsp.action = (in_word.mode == 3'(MODE_MUL)) ? ACT_SHL :
               (in_word.mode == 3'(MODE_UDIV)) ? ACT_LSHR : ACT_ASHR;
            job_in.rsp.result_value = ValueBits'(tz);
            job_in.rsp.operand_ref = s_lr;
         end else begin
            job_in.rsp.action = ACT_KEEP;
         end
      end
   end

   // Output register of the front part.
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      job_ff <= job_in;
   end

   assign out_valid = valid_ff;
   assign out_job = job_ff;

endmodule

FILE: src/bps_back.sv
// Back part: folds add, sub and mul, and runs a pipelined restoring divider.
module bps_back import bps_pkg::*; #(
   parameter int unsigned WIDTH = DefaultWidth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  job_type in_job,
   output logic    out_valid,
   output rsp_type out_word
);

   localparam int unsigned Stages = WIDTH;

   // One quotient bit per stage.
   logic             v_ff [Stages+1];
   job_type          j_ff [Stages+1];
   logic [WIDTH-1:0] r_ff [Stages+1];
   logic [WIDTH-1:0] q_ff [Stages+1];
   logic [WIDTH-1:0] q_in [Stages];
   logic [WIDTH-1:0] r_in [Stages];
   logic [WIDTH-1:0] prod_ff;
   logic [WIDTH-1:0] a_w, b_w, arith;
   logic [WIDTH-1:0] fin_q;
   rsp_type          rsp_in, rsp_ff;
   logic             ovalid_ff;

   // Entry stage: register the product so no adder follows the multiplier.
   always_comb begin
      a_w = WIDTH'(in_job.a);
      b_w = WIDTH'(in_job.b);
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_valid;
      j_ff[0] <= in_job;
      r_ff[0] <= '0;
      q_ff[0] <= a_w;
      prod_ff <= a_w * b_w;
   end

   // Restoring division steps; the dividend shifts out of q as quotient bits shift in.
   for (genvar s = 0; s < Stages; s++) begin : g_div
      logic [WIDTH:0] trial;
      always_comb begin
         trial = '0;
         r_in[s] = r_ff[s];
         q_in[s] = q_ff[s];
         trial = {r_ff[s], q_ff[s][WIDTH-1]} - {1'b0, WIDTH'(j_ff[s].b)};
         if (!trial[WIDTH]) begin
            r_in[s] = trial[WIDTH-1:0];
            q_in[s] = {q_ff[s][WIDTH-2:0], 1'b1};
         end else begin
            r_in[s] = {r_ff[s][WIDTH-2:0], q_ff[s][WIDTH-1]};
            q_in[s] = {q_ff[s][WIDTH-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[s+1] <= 1'b0;
         else v_ff[s+1] <= v_ff[s];
         j_ff[s+1] <= j_ff[s];
         r_ff[s+1] <= r_in[s];
         q_ff[s+1] <= q_in[s];
      end
   end

   // Result selection at the end of the pipeline.
   logic [WIDTH-1:0] prod_d [Stages];
   always_ff @(posedge clock) begin
      prod_d[0] <= prod_ff;
      for (int k = 1; k < Stages; k++) prod_d[k] <= prod_d[k-1];
   end

   always_comb begin
      rsp_in = j_ff[Stages].rsp;
      fin_q = q_ff[Stages];
      unique case (j_ff[Stages].cls)
         CLS_ARITH: begin
            unique case (j_ff[Stages].mode)
               3'(MODE_ADD): arith = WIDTH'(j_ff[Stages].a) + WIDTH'(j_ff[Stages].b);
               3'(MODE_SUB): arith = WIDTH'(j_ff[Stages].a) - WIDTH'(j_ff[Stages].b);
               default:      arith = prod_d[Stages-1];
            endcase
            rsp_in.action = ACT_FOLD;
            rsp_in.result_value = ValueBits'(arith);
         end
         CLS_UDIV: begin
            arith = '0;
            rsp_in.action = ACT_FOLD;
            rsp_in.result_value = ValueBits'(fin_q);
         end
         CLS_SDIV: begin
            arith = '0;
            rsp_in.action = ACT_FOLD;
            rsp_in.result_value = ValueBits'((j_ff[Stages].a_neg != j_ff[Stages].b_neg)
                                             ? (~fin_q + 1'b1) : fin_q);
         end
         default: arith = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) ovalid_ff <= 1'b0;
      else ovalid_ff <= v_ff[Stages];
      rsp_ff <= rsp_in;
   end

   assign out_valid = ovalid_ff;
   assign out_word = rsp_ff;

`ifndef NO_ASSERTIONS
   // A word that enters is not lost: it leaves after the entry stage, every divider stage and the output register.
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##(Stages + 2) out_valid)
      else $error("divider pipeline lost a word");
   // A divide flag always comes with a keep action.
   a_dz: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_word.div_by_zero |-> out_word.action == ACT_KEEP)
      else $error("divide flag with non-keep action");
   // Nothing appears at the output without an entry.
   a_src: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(v_ff[Stages]))
      else $error("spurious result");
`endif

endmodule
